@@ src/endless_pot_position_tracker_defines.svh @@
// Assertion macros shared by the position tracker modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ENDLESS_POT_POSITION_TRACKER_DEFINES_SVH
`define ENDLESS_POT_POSITION_TRACKER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define EPT_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EPT_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ept_pkg.sv @@
// Constants, tables, types and helpers for the endless pot position tracker.
// No dependencies; imported by every module of the block.
package ept_pkg;

    // register and field sizes
    localparam int SENS_W        = 7;
    localparam int SENS_RESET    = 80;
    localparam int SENS_LIMIT    = 100;
    localparam int SENS_DIVISOR  = 11;
    localparam int REVS_W        = 4;
    localparam int REVS_MAX      = 10;
    localparam int POS_W         = 12;
    localparam int SUM_W         = 15;
    localparam int SUM_SHIFT     = 3;
    localparam int FULL_SCALE    = 4095;

    // dial and accumulator
    localparam int DIAL_STEPS    = 256;
    localparam int DIAL_BITS     = $clog2(DIAL_STEPS);
    localparam int MAG_W         = DIAL_BITS;
    localparam int DELTA_W       = DIAL_BITS + 2;
    localparam int NOISE_FLOOR   = 2;
    localparam int FRACTION_BITS = 16;
    localparam int ACC_W         = POS_W + FRACTION_BITS;
    localparam logic [ACC_W-1:0] ACC_TOP   = ACC_W'(FULL_SCALE) << FRACTION_BITS;
    localparam logic [ACC_W-1:0] ACC_RESET = ACC_W'(FULL_SCALE) << (FRACTION_BITS - 1);

    // CORDIC
    localparam int CORDIC_ITERATIONS = 16;
    localparam int TABLE_LEN     = 24;
    localparam int ITER_W        = $clog2(TABLE_LEN);
    localparam int XY_SCALE_BITS = 24;
    localparam int COORD_W       = 13;
    localparam int XY_W          = COORD_W + 3 + XY_SCALE_BITS;
    localparam int ANGLE_FRAC    = 32;
    localparam int ANGLE_W       = ANGLE_FRAC + 2;
    localparam int DIAL_WIDE_W   = ANGLE_W - 1 - (ANGLE_FRAC - DIAL_BITS);
    localparam logic signed [ANGLE_W-1:0] HALF_TURN =
        {{(ANGLE_W - ANGLE_FRAC){1'b0}}, 1'b1, {(ANGLE_FRAC - 1){1'b0}}};

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ANGLE_FRAC-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // increment per dial step: INC_SCALE / revs, split as quotient and remainder
    localparam int INC_SCALE   = (FULL_SCALE << FRACTION_BITS) / DIAL_STEPS;
    localparam int INC_QUOT_W  = 20;
    localparam int INC_REM_W   = 4;
    localparam int RECIP_SHIFT = 15;
    localparam int RECIP_W     = 16;
    localparam int HI_W        = INC_QUOT_W + MAG_W;
    localparam int LO_V_W      = INC_REM_W + MAG_W;
    localparam int LO_Q_W      = LO_V_W + RECIP_W - RECIP_SHIFT;
    localparam int REVS_TABLE  = 1 << REVS_W;

    localparam logic [INC_QUOT_W-1:0] INC_QUOT [REVS_TABLE] = '{
        INC_QUOT_W'(INC_SCALE),      INC_QUOT_W'(INC_SCALE),
        INC_QUOT_W'(INC_SCALE / 2),  INC_QUOT_W'(INC_SCALE / 3),
        INC_QUOT_W'(INC_SCALE / 4),  INC_QUOT_W'(INC_SCALE / 5),
        INC_QUOT_W'(INC_SCALE / 6),  INC_QUOT_W'(INC_SCALE / 7),
        INC_QUOT_W'(INC_SCALE / 8),  INC_QUOT_W'(INC_SCALE / 9),
        INC_QUOT_W'(INC_SCALE / 10), INC_QUOT_W'(INC_SCALE),
        INC_QUOT_W'(INC_SCALE),      INC_QUOT_W'(INC_SCALE),
        INC_QUOT_W'(INC_SCALE),      INC_QUOT_W'(INC_SCALE)
    };

    localparam logic [INC_REM_W-1:0] INC_REM [REVS_TABLE] = '{
        INC_REM_W'(0),              INC_REM_W'(0),
        INC_REM_W'(INC_SCALE % 2),  INC_REM_W'(INC_SCALE % 3),
        INC_REM_W'(INC_SCALE % 4),  INC_REM_W'(INC_SCALE % 5),
        INC_REM_W'(INC_SCALE % 6),  INC_REM_W'(INC_SCALE % 7),
        INC_REM_W'(INC_SCALE % 8),  INC_REM_W'(INC_SCALE % 9),
        INC_REM_W'(INC_SCALE % 10), INC_REM_W'(0),
        INC_REM_W'(0),              INC_REM_W'(0),
        INC_REM_W'(0),              INC_REM_W'(0)
    };

    // floor(2^15 / revs) + 1 gives exact quotients for the remainder products
    localparam logic [RECIP_W-1:0] INC_RECIP [REVS_TABLE] = '{
        RECIP_W'((1 << RECIP_SHIFT) + 1),      RECIP_W'((1 << RECIP_SHIFT) + 1),
        RECIP_W'((1 << RECIP_SHIFT) / 2 + 1),  RECIP_W'((1 << RECIP_SHIFT) / 3 + 1),
        RECIP_W'((1 << RECIP_SHIFT) / 4 + 1),  RECIP_W'((1 << RECIP_SHIFT) / 5 + 1),
        RECIP_W'((1 << RECIP_SHIFT) / 6 + 1),  RECIP_W'((1 << RECIP_SHIFT) / 7 + 1),
        RECIP_W'((1 << RECIP_SHIFT) / 8 + 1),  RECIP_W'((1 << RECIP_SHIFT) / 9 + 1),
        RECIP_W'((1 << RECIP_SHIFT) / 10 + 1), RECIP_W'((1 << RECIP_SHIFT) + 1),
        RECIP_W'((1 << RECIP_SHIFT) + 1),      RECIP_W'((1 << RECIP_SHIFT) + 1),
        RECIP_W'((1 << RECIP_SHIFT) + 1),      RECIP_W'((1 << RECIP_SHIFT) + 1)
    };

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        Z_NONE,
        Z_PLUS_HALF,
        Z_MINUS_HALF
    } zstart_t;

    typedef struct packed {
        logic                      is_set;
        logic [POS_W-1:0]          set_position;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        zstart_t                   z_start;
    } cmd_t;

    // revs = clamp(1 + (100 - s) / 11, 1, 10), by threshold compares
    function automatic logic [REVS_W-1:0] revs_of(input logic [SENS_W-1:0] s);
        logic [SENS_W-1:0] t;
        logic [REVS_W-1:0] r;
        t = (s < SENS_W'(SENS_LIMIT)) ? SENS_W'(SENS_W'(SENS_LIMIT) - s) : '0;
        r = REVS_W'(1);
        for (int k = 1; k < REVS_MAX; k++) begin
            if (t >= SENS_W'(SENS_DIVISOR * k)) begin
                r = REVS_W'(r + 1'b1);
            end
        end
        return r;
    endfunction

    localparam logic [REVS_W-1:0] REVS_RESET = revs_of(SENS_W'(SENS_RESET));

endpackage

@@ src/endless_pot_position_tracker.sv @@
// Endless pot position tracker: a moving sample runs 16 CORDIC iterations and then
// the dial, delta, multiply, reciprocal and update steps; a sync or small move stops
// after the delta step, and a set goes straight to the output. The back end runs one
// item at a time; a two-entry queue keeps the input open while the back end and the
// output are busy. Reset (rst_n low, asynchronous) gives accumulated position 2047.5,
// dial 0, resync on the first sample and sensitivity 80; no memory needs clearing.
module endless_pot_position_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [ept_pkg::SUM_W-1:0]     track_a_sum,
    input  logic [ept_pkg::SUM_W-1:0]     track_b_sum,
    input  logic [ept_pkg::POS_W-1:0]     set_position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ept_pkg::POS_W-1:0]     position,
    output logic [ept_pkg::DIAL_BITS-1:0] dial,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ept_pkg::SENS_W-1:0]    sensitivity
);
    import ept_pkg::*;

    logic              q_full;
    logic              q_push;
    cmd_t              q_push_cmd;
    logic              q_pop;
    cmd_t              q_pop_cmd;
    logic              q_not_empty;
    logic [REVS_W-1:0] revs_reg;
    logic [REVS_W-1:0] revs_next;

    // keep the decoded revolutions per range rather than the raw register
    assign cfg_ready = 1'b1;
    assign revs_next = (cfg_valid && cfg_ready) ? revs_of(sensitivity) : revs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            revs_reg <= REVS_RESET;
        end
        else
        begin
            revs_reg <= revs_next;
        end
    end

    ept_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .track_a_sum  (track_a_sum),
        .track_b_sum  (track_b_sum),
        .set_position (set_position),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_push_cmd)
    );

    ept_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_pop_cmd),
        .not_empty (q_not_empty)
    );

    ept_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_cmd     (q_pop_cmd),
        .q_pop     (q_pop),
        .revs      (revs_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .position  (position),
        .dial      (dial)
    );

endmodule

@@ src/ept_front.sv @@
// Front end: takes input transactions, centers the track sums and folds the
// left half plane, then pushes a command into the queue. Uses ept_pkg.
module ept_front (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [ept_pkg::SUM_W-1:0]   track_a_sum,
    input  logic [ept_pkg::SUM_W-1:0]   track_b_sum,
    input  logic [ept_pkg::POS_W-1:0]   set_position,
    input  logic                        q_full,
    output logic                        q_push,
    output ept_pkg::cmd_t               q_cmd
);
    import ept_pkg::*;

    logic [POS_W-1:0]          a;
    logic [POS_W-1:0]          b;
    logic signed [COORD_W:0]   x_wide;
    logic signed [COORD_W:0]   y_wide;
    logic signed [COORD_W:0]   x_neg;
    logic signed [COORD_W:0]   y_neg;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign a      = track_a_sum[SUM_W-1:SUM_SHIFT];
    assign b      = track_b_sum[SUM_W-1:SUM_SHIFT];
    assign x_wide = $signed({1'b0, a, 1'b0}) - $signed((COORD_W + 1)'(FULL_SCALE));
    assign y_wide = $signed({1'b0, b, 1'b0}) - $signed((COORD_W + 1)'(FULL_SCALE));
    assign x_neg  = -x_wide;
    assign y_neg  = -y_wide;

    always_comb
    begin
        q_cmd.is_set       = kind;
        q_cmd.set_position = set_position;
        if (x_wide[COORD_W])
        begin
            // rotate by half a turn so the vector starts in the right half plane
            q_cmd.x       = x_neg[COORD_W-1:0];
            q_cmd.y       = y_neg[COORD_W-1:0];
            q_cmd.z_start = y_wide[COORD_W] ? Z_MINUS_HALF : Z_PLUS_HALF;
        end
        else
        begin
            q_cmd.x       = x_wide[COORD_W-1:0];
            q_cmd.y       = y_wide[COORD_W-1:0];
            q_cmd.z_start = Z_NONE;
        end
    end

endmodule

@@ src/ept_queue.sv @@
// Short command queue between front and back end.
// Uses ept_pkg (cmd_t, QUEUE_DEPTH) and the assertion macro header.
`include "endless_pot_position_tracker_defines.svh"
module ept_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ept_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output ept_pkg::cmd_t pop_cmd,
    output logic          not_empty
);
    import ept_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `EPT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `EPT_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !push, count_reg == QCNT_W'($past(count_reg) - 1'b1), "pop without push did not drain queue")

endmodule

@@ src/ept_back.sv @@
// Back end: iterative CORDIC, dial wrap, scaled increment and saturating
// accumulator, with the output register. Uses ept_pkg and the macro header.
`include "endless_pot_position_tracker_defines.svh"
module ept_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  ept_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    input  logic [ept_pkg::REVS_W-1:0]    revs,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ept_pkg::POS_W-1:0]     position,
    output logic [ept_pkg::DIAL_BITS-1:0] dial
);
    import ept_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_DIAL,
        S_DELTA,
        S_MUL,
        S_RECIP,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    logic                      out_valid_reg, out_valid_next;
    logic [POS_W-1:0]          position_reg, position_next;
    logic [DIAL_BITS-1:0]      dial_reg, dial_next;

    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [DIAL_BITS-1:0]      prev_dial_reg, prev_dial_next;
    logic                      prev_valid_reg, prev_valid_next;
    logic [DIAL_BITS-1:0]      latest_dial_reg, latest_dial_next;

    logic signed [XY_W-1:0]    cx_reg, cx_next;
    logic signed [XY_W-1:0]    cy_reg, cy_next;
    logic signed [ANGLE_W-1:0] cz_reg, cz_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic [HI_W-1:0]           hi_reg, hi_next;
    logic [LO_V_W-1:0]         lo_v_reg, lo_v_next;
    logic [LO_Q_W-1:0]         lo_q_reg, lo_q_next;

    logic signed [XY_W-1:0]    xs;
    logic signed [XY_W-1:0]    ys;
    logic signed [ANGLE_W-1:0] atan_step;
    logic signed [ANGLE_W-1:0] z_offset;
    logic [DIAL_WIDE_W-1:0]    dial_wide;
    logic signed [DELTA_W-1:0] delta_raw;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DELTA_W-1:0] delta_abs;
    logic [LO_V_W+RECIP_W-1:0] lo_prod;
    logic [ACC_W-1:0]          inc;
    logic signed [ACC_W+1:0]   acc_sum;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign dial      = dial_reg;

    assign xs        = cx_reg >>> iter_reg;
    assign ys        = cy_reg >>> iter_reg;
    assign atan_step = $signed({{(ANGLE_W - ANGLE_FRAC){1'b0}}, ATAN_TURNS[iter_reg]});
    assign z_offset  = cz_reg + HALF_TURN;
    assign dial_wide = z_offset[ANGLE_W-2:ANGLE_FRAC-DIAL_BITS];
    assign delta_raw = $signed({2'b00, latest_dial_reg}) - $signed({2'b00, prev_dial_reg});
    assign lo_prod   = (LO_V_W + RECIP_W)'(lo_v_reg)
                     * (LO_V_W + RECIP_W)'(INC_RECIP[revs]);
    assign inc       = ACC_W'(hi_reg) + ACC_W'(lo_q_reg);
    assign acc_sum   = neg_reg ? $signed({2'b00, acc_reg}) - $signed({2'b00, inc})
                               : $signed({2'b00, acc_reg}) + $signed({2'b00, inc});

    // shortest path around the dial
    always_comb
    begin
        delta = delta_raw;
        if (delta_raw > $signed(DELTA_W'(DIAL_STEPS / 2)))
        begin
            delta = delta_raw - $signed(DELTA_W'(DIAL_STEPS));
        end
        else if (delta_raw < -$signed(DELTA_W'(DIAL_STEPS / 2)))
        begin
            delta = delta_raw + $signed(DELTA_W'(DIAL_STEPS));
        end
        delta_abs = delta[DELTA_W-1] ? -delta : delta;
    end

    always_comb
    begin
        state_next       = state_reg;
        iter_next        = iter_reg;
        out_valid_next   = out_valid_reg;
        position_next    = position_reg;
        dial_next        = dial_reg;
        acc_next         = acc_reg;
        prev_dial_next   = prev_dial_reg;
        prev_valid_next  = prev_valid_reg;
        latest_dial_next = latest_dial_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        cz_next          = cz_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        hi_next          = hi_reg;
        lo_v_next        = lo_v_reg;
        lo_q_next        = lo_q_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.is_set)
                    begin
                        acc_next        = {q_cmd.set_position, {FRACTION_BITS{1'b0}}};
                        prev_valid_next = 1'b0;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        cx_next   = $signed({{(XY_W - COORD_W){q_cmd.x[COORD_W-1]}}, q_cmd.x})
                                    <<< XY_SCALE_BITS;
                        cy_next   = $signed({{(XY_W - COORD_W){q_cmd.y[COORD_W-1]}}, q_cmd.y})
                                    <<< XY_SCALE_BITS;
                        case (q_cmd.z_start)
                            Z_PLUS_HALF:  cz_next = HALF_TURN;
                            Z_MINUS_HALF: cz_next = -HALF_TURN;
                            default:      cz_next = '0;
                        endcase
                        iter_next  = '0;
                        state_next = S_CORDIC;
                    end
                end
            end
            S_CORDIC:
            begin
                // rotate toward y = 0
                if (!cy_reg[XY_W-1])
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + atan_step;
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - atan_step;
                end
                if (iter_reg == ITER_W'(CORDIC_ITERATIONS - 1))
                begin
                    state_next = S_DIAL;
                end
                else
                begin
                    iter_next = ITER_W'(iter_reg + 1'b1);
                end
            end
            S_DIAL:
            begin
                if (z_offset[ANGLE_W-1])
                begin
                    latest_dial_next = '0;
                end
                else if (dial_wide > DIAL_WIDE_W'(DIAL_STEPS - 1))
                begin
                    latest_dial_next = DIAL_BITS'(DIAL_STEPS - 1);
                end
                else
                begin
                    latest_dial_next = dial_wide[DIAL_BITS-1:0];
                end
                state_next = S_DELTA;
            end
            S_DELTA:
            begin
                prev_dial_next = latest_dial_reg;
                if (!prev_valid_reg)
                begin
                    // first sample after reset or set: sync only
                    prev_valid_next = 1'b1;
                    state_next      = S_FINISH;
                end
                else if (delta_abs >= $signed(DELTA_W'(NOISE_FLOOR)))
                begin
                    mag_next   = delta_abs[MAG_W-1:0];
                    neg_next   = delta[DELTA_W-1];
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_MUL:
            begin
                hi_next    = HI_W'(mag_reg) * HI_W'(INC_QUOT[revs]);
                lo_v_next  = LO_V_W'(mag_reg) * LO_V_W'(INC_REM[revs]);
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                lo_q_next  = lo_prod[LO_V_W+RECIP_W-1:RECIP_SHIFT];
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (acc_sum[ACC_W+1])
                begin
                    acc_next = '0;
                end
                else if (acc_sum > $signed({2'b00, ACC_TOP}))
                begin
                    acc_next = ACC_TOP;
                end
                else
                begin
                    acc_next = acc_sum[ACC_W-1:0];
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    position_next  = acc_reg[ACC_W-1:FRACTION_BITS];
                    dial_next      = latest_dial_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            position_reg  <= '0;
            dial_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            position_reg  <= position_next;
            dial_reg      <= dial_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg         <= ACC_RESET;
            prev_dial_reg   <= '0;
            prev_valid_reg  <= 1'b0;
            latest_dial_reg <= '0;
        end
        else
        begin
            acc_reg         <= acc_next;
            prev_dial_reg   <= prev_dial_next;
            prev_valid_reg  <= prev_valid_next;
            latest_dial_reg <= latest_dial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        hi_reg   <= hi_next;
        lo_v_reg <= lo_v_next;
        lo_q_reg <= lo_q_next;
    end

    `EPT_ASSERT_ALWAYS(a_acc_in_range, clk, rst_n, acc_reg <= ACC_TOP, "accumulator above full scale")
    `EPT_ASSERT_ALWAYS(a_iter_bound, clk, rst_n, (state_reg != S_CORDIC) || (iter_reg < ITER_W'(CORDIC_ITERATIONS)), "CORDIC iteration count overrun")
    `EPT_ASSERT_NEXT(a_out_drops, clk, rst_n, out_valid_reg && out_ready && (state_reg != S_FINISH), !out_valid_reg, "result repeated after transaction")

endmodule

@@ bench/tb_endless_pot_position_tracker.sv @@
// Self-checking bench for endless_pot_position_tracker: directed table, then random knob turns.
// Uses ept_pkg for port widths; predicts position and dial with its own CORDIC and accumulator.
`timescale 1ns / 100ps

module tb_endless_pot_position_tracker;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 30;
    localparam int     PHASE_ITEMS  = 86;
    localparam int     RIM_STEPS    = 16384;
    localparam int     DEAD_BAND    = 2;
    localparam int     HALF_DIAL    = 128;
    localparam longint HALF_REV     = 64'sd2147483648;
    localparam longint ACC_ONE      = 64'sd65536;
    localparam longint FULL_FX      = 64'sd4095 * ACC_ONE;

    typedef enum bit {
        KIND_SAMPLE = 1'b0,
        KIND_SET    = 1'b1
    } knob_kind_t;

    typedef struct {
        knob_kind_t  kind;
        logic [14:0] a_sum;
        logic [14:0] b_sum;
        logic [11:0] set_pos;
    } knob_item_t;

    typedef struct {
        logic [11:0] position;
        logic [7:0]  dial;
    } reading_t;

    typedef struct {
        knob_item_t item;
        bit         typed;
        reading_t   want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            kind = 1'b0;
    logic [ept_pkg::SUM_W-1:0]       track_a_sum = '0;
    logic [ept_pkg::SUM_W-1:0]       track_b_sum = '0;
    logic [ept_pkg::POS_W-1:0]       set_position = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [ept_pkg::POS_W-1:0]       position;
    logic [ept_pkg::DIAL_BITS-1:0]   dial;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ept_pkg::SENS_W-1:0]      sensitivity = 7'd80;

    // tracker state as the bench sees it
    longint      acc_fx = FULL_FX / 2;
    logic [7:0]  prev_dial = 8'd0;
    logic [7:0]  last_dial = 8'd0;
    bit          synced = 1'b0;
    logic [6:0]  sens_reg = 7'd80;

    reading_t    pending_readings [$];
    stim_row_t   rows [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_pct = 0;
    int          rim_pos = 0;
    int          spin_dir = 1;

    int phase_sens  [5] = '{100, 0, 127, 23, 0};
    int phase_idle  [5] = '{0, 49, 0, 22, 0};
    int phase_stall [5] = '{0, 0, 49, 22, 0};

    endless_pot_position_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .track_a_sum  (track_a_sum),
        .track_b_sum  (track_b_sum),
        .set_position (set_position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position     (position),
        .dial         (dial),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .sensitivity  (sensitivity)
    );

    always #6 clk = ~clk;

    // atan(2^-i) in units of 2^-32 turn
    function automatic longint atan_step(int i);
        case (i)
            0:       return 64'h20000000;
            1:       return 64'h12E4051E;
            2:       return 64'h09FB385B;
            3:       return 64'h051111D4;
            4:       return 64'h028B0D43;
            5:       return 64'h0145D7E1;
            6:       return 64'h00A2F61E;
            7:       return 64'h00517C55;
            8:       return 64'h0028BE53;
            9:       return 64'h00145F2F;
            10:      return 64'h000A2F98;
            11:      return 64'h000517CC;
            12:      return 64'h00028BE6;
            13:      return 64'h000145F3;
            14:      return 64'h0000A2FA;
            15:      return 64'h0000517D;
            default: return 64'h0;
        endcase
    endfunction

    function automatic logic [7:0] dial_of(logic [14:0] a_sum, logic [14:0] b_sum);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint d;
        x = (2 * longint'(a_sum >> 3) - 4095) * 64'sd16777216;
        y = (2 * longint'(b_sum >> 3) - 4095) * 64'sd16777216;
        z = 0;
        // fold the left half plane onto the right one
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_REV : -HALF_REV;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        z = z + HALF_REV;
        if (z < 0)
            z = 0;
        d = (z * 256) >>> 32;
        if (d > 255)
            d = 255;
        return d[7:0];
    endfunction

    function automatic longint turns_per_range(logic [6:0] s);
        int r;
        if (s >= 7'd100)
            return 1;
        r = 1 + (100 - int'(s)) / 11;
        return (r > 10) ? 10 : r;
    endfunction

    function automatic reading_t track_knob(knob_item_t it);
        reading_t   r;
        logic [7:0] d;
        int         delta;
        longint     mag;
        longint     step;
        if (it.kind == KIND_SET)
        begin
            acc_fx = longint'(it.set_pos) * ACC_ONE;
            synced = 1'b0;
        end
        else
        begin
            d = dial_of(it.a_sum, it.b_sum);
            last_dial = d;
            if (!synced)
            begin
                prev_dial = d;
                synced = 1'b1;
            end
            else
            begin
                delta = int'(d) - int'(prev_dial);
                prev_dial = d;
                // take the shorter way around the dial
                if (delta > HALF_DIAL)
                    delta = delta - 2 * HALF_DIAL;
                if (delta < -HALF_DIAL)
                    delta = delta + 2 * HALF_DIAL;
                if (delta >= DEAD_BAND || delta <= -DEAD_BAND)
                begin
                    mag = (delta < 0) ? -delta : delta;
                    step = (mag * 4095 * ACC_ONE) / (256 * turns_per_range(sens_reg));
                    acc_fx = (delta < 0) ? acc_fx - step : acc_fx + step;
                    if (acc_fx < 0)
                        acc_fx = 0;
                    if (acc_fx > FULL_FX)
                        acc_fx = FULL_FX;
                end
            end
        end
        r.position = 12'(acc_fx >>> 16);
        r.dial = last_dial;
        return r;
    endfunction

    // walk around the rim of the square; angle grows with p
    function automatic knob_item_t rim_sample(int p);
        knob_item_t  it;
        int          seg;
        int          off;
        logic [11:0] a;
        logic [11:0] b;
        seg = p / 4096;
        off = p % 4096;
        case (seg)
            0:
            begin
                a = 12'd4095;
                b = 12'(off);
            end
            1:
            begin
                a = 12'(4095 - off);
                b = 12'd4095;
            end
            2:
            begin
                a = 12'd0;
                b = 12'(4095 - off);
            end
            default:
            begin
                a = 12'(off);
                b = 12'd0;
            end
        endcase
        it.kind = KIND_SAMPLE;
        it.a_sum = {a, 3'($urandom_range(7))};
        it.b_sum = {b, 3'($urandom_range(7))};
        it.set_pos = 12'($urandom_range(4095));
        return it;
    endfunction

    function automatic knob_item_t random_item();
        knob_item_t it;
        int         roll;
        int         mag;
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            it.kind = (roll < 5) ? KIND_SET : KIND_SAMPLE;
            it.a_sum = 15'($urandom_range(32767));
            it.b_sum = 15'($urandom_range(32767));
            it.set_pos = 12'($urandom_range(4095));
            return it;
        end
        if ($urandom_range(99) < 15)
            spin_dir = -spin_dir;
        roll = $urandom_range(99);
        if (roll < 30)
            mag = $urandom_range(150);
        else if (roll < 80)
            mag = $urandom_range(2000);
        else
            mag = $urandom_range(8000);
        rim_pos = (rim_pos + spin_dir * mag + RIM_STEPS) % RIM_STEPS;
        return rim_sample(rim_pos);
    endfunction

    function automatic stim_row_t dir_row(knob_kind_t k, int a, int b, int sp,
                                          bit typed = 1'b0, int pos = 0, int dl = 0);
        stim_row_t r;
        r.item.kind = k;
        r.item.a_sum = 15'(a);
        r.item.b_sum = 15'(b);
        r.item.set_pos = 12'(sp);
        r.typed = typed;
        r.want.position = 12'(pos);
        r.want.dial = 8'(dl);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want_v);
        error_count++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want_v);
    endtask

    task automatic send_item(knob_item_t it, bit typed, reading_t want);
        reading_t model;
        in_valid <= 1'b1;
        kind <= it.kind;
        track_a_sum <= it.a_sum;
        track_b_sum <= it.b_sum;
        set_position <= it.set_pos;
        do @(posedge clk); while (!in_ready);
        model = track_knob(it);
        pending_readings.push_back(typed ? want : model);
    endtask

    task automatic drain_readings();
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    task automatic write_sensitivity(logic [6:0] v);
        drain_readings();
        cfg_valid <= 1'b1;
        sensitivity <= v;
        do @(posedge clk); while (!cfg_ready);
        sens_reg = v;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("position of unrequested transaction", position, -1);
            else
            begin
                want = pending_readings.pop_front();
                if (position !== want.position)
                    report_mismatch("position", position, want.position);
                if (dial !== want.dial)
                    report_mismatch("dial", dial, want.dial);
            end
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[endless_pot_position_tracker] ERROR");
            $finish;
        end
    end

    initial
    begin
        knob_item_t it;
        reading_t   none;
        none.position = '0;
        none.dial = '0;

        // sync after reset, dead band, set extremes, dial wrap at the half turn,
        // saturation at both ends, ignored fields, field extremes
        rows.push_back(dir_row(KIND_SAMPLE, 32760, 16392, 0, 1'b1, 2047, 128));
        rows.push_back(dir_row(KIND_SAMPLE, 32767, 16399, 4095));
        rows.push_back(dir_row(KIND_SET, 0, 0, 4095, 1'b1, 4095, 128));
        rows.push_back(dir_row(KIND_SAMPLE, 32760, 16392, 0, 1'b1, 4095, 128));
        rows.push_back(dir_row(KIND_SAMPLE, 16384, 32760, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 16392, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 16376, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 14400, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 16392, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 0, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 32767, 0));
        rows.push_back(dir_row(KIND_SET, 32767, 32767, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 32767, 32767, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 32767, 0, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 0, 0));
        rows.push_back(dir_row(KIND_SET, 32767, 32767, 2048));
        rows.push_back(dir_row(KIND_SAMPLE, 0, 0, 4095));
        rows.push_back(dir_row(KIND_SAMPLE, 8, 8, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 7, 32767, 0));
        rows.push_back(dir_row(KIND_SAMPLE, 32767, 7, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].want);
        in_valid <= 1'b0;

        for (int p = 0; p < 5; p++)
        begin
            write_sensitivity((p == 4) ? 7'($urandom_range(127)) : 7'(phase_sens[p]));
            stall_pct = phase_stall[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off once until the output side has caught up
                if (p == 2 && n == 40)
                begin
                    in_valid <= 1'b0;
                    drain_readings();
                end
                else
                begin
                    while ($urandom_range(99) < phase_idle[p])
                    begin
                        in_valid <= 1'b0;
                        @(posedge clk);
                    end
                end
                it = random_item();
                send_item(it, 1'b0, none);
            end
            in_valid <= 1'b0;
        end

        drain_readings();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[endless_pot_position_tracker] OK");
        else
            $display("[endless_pot_position_tracker] ERROR");
        $finish;
    end

endmodule

@@ endless_pot_position_tracker.f @@
+incdir+src
src/ept_pkg.sv
src/ept_front.sv
src/ept_queue.sv
src/ept_back.sv
src/endless_pot_position_tracker.sv
bench/tb_endless_pot_position_tracker.sv
